@@ hw/rtl/sine_voice_with_release_defines.svh @@
// ----------------------------------------------------------------------------
// sine_voice_with_release_defines.svh
// Assertion macros shared by the voice RTL.
// ----------------------------------------------------------------------------
`ifndef SINE_VOICE_WITH_RELEASE_DEFINES_SVH
`define SINE_VOICE_WITH_RELEASE_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define SVR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define SVR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/svr_pkg.sv @@
// ----------------------------------------------------------------------------
// svr_pkg
// Types, constants and ROM builders for the sine voice with release.
// ----------------------------------------------------------------------------
package svr_pkg;

    localparam int SINE_TABLE_SIZE = 1024;
    localparam int SAMPLE_RATE     = 48000;
    localparam int SINE_IDX_W      = $clog2(SINE_TABLE_SIZE);
    localparam int NOTE_CNT        = 128;

    // Operation codes of an input word.
    localparam logic [1:0] OP_TICK     = 2'd0;
    localparam logic [1:0] OP_NOTE_ON  = 2'd1;
    localparam logic [1:0] OP_NOTE_OFF = 2'd2;
    localparam logic [1:0] OP_KILL     = 2'd3;

    localparam logic [6:0]  VOL_MAX     = 7'd100;
    localparam logic [6:0]  VOL_RESET   = 7'd100;
    localparam logic [15:0] GAIN_ONE    = 16'd32768;
    localparam logic [15:0] GAIN_STOP   = 16'd163;
    localparam logic [14:0] DECAY_Q15   = 15'd32440;

    // Level = round(vel * vol * 98304 / 127000), the division done as an exact
    // reciprocal multiply: the numerator stays below 2^31 and 127000 < 2^17.
    localparam logic [16:0] LEVEL_SCALE = 17'd98304;
    localparam logic [15:0] LEVEL_ROUND = 16'd63500;
    localparam int          LEVEL_SHIFT = 48;
    localparam logic [63:0] LEVEL_RECIP_W =
        ((64'd1 << LEVEL_SHIFT) + 64'd126999) / 64'd127000;
    localparam logic [31:0] LEVEL_RECIP = LEVEL_RECIP_W[31:0];

    localparam logic [63:0] STEP_DEN = 64'd1000 * 64'(SAMPLE_RATE);

    localparam logic [63:0] Q30_ONE     = 64'd1073741824;
    localparam logic [63:0] Q30_TWO_PI  = 64'd6746518852;
    localparam logic [63:0] Q30_PI      = 64'd3373259426;
    localparam logic [63:0] Q30_HALF_PI = 64'd1686629713;

    typedef struct packed {
        logic [31:0] phase;
        logic [31:0] step;
        logic [15:0] level;
        logic [15:0] gain;
        logic        releasing;
        logic        sounding;
    } t_voice;

    typedef logic signed [15:0] t_sine_tab [SINE_TABLE_SIZE];
    typedef logic [31:0]        t_step_tab [NOTE_CNT];

    function automatic logic signed [15:0] sine_at(input logic [63:0] idx);
        logic [63:0]        th;
        logic [63:0]        x2;
        logic [63:0]        t;
        logic [63:0]        s;
        logic [63:0]        q;
        logic               neg;
        logic signed [15:0] v;
        th  = (idx * Q30_TWO_PI + 64'(SINE_TABLE_SIZE / 2)) / 64'(SINE_TABLE_SIZE);
        neg = 1'b0;
        if (th >= Q30_PI) begin
            neg = 1'b1;
            th  = th - Q30_PI;
        end
        if (th > Q30_HALF_PI) begin
            th = (Q30_PI > th) ? Q30_PI - th : 64'd0;
        end
        // Nested Taylor series of sin(x)/x, innermost term first.
        x2 = (th * th) >> 30;
        t  = Q30_ONE;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd110;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd72;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
        s  = (th * t) >> 30;
        q  = (s * 64'd32767 + (64'd1 << 29)) >> 30;
        if (q > 64'd32767) begin
            q = 64'd32767;
        end
        v = 16'(q);
        return neg ? -v : v;
    endfunction

    function automatic t_sine_tab build_sine();
        t_sine_tab tab;
        for (int i = 0; i < SINE_TABLE_SIZE; i++) begin
            tab[i] = sine_at(64'(i));
        end
        return tab;
    endfunction

    function automatic logic [31:0] step_at(input int n);
        logic [63:0] mhz;
        logic [63:0] num;
        logic [3:0]  octave;
        int          key;
        octave = 4'(n / 12);
        key    = n % 12;
        case (key)
            0:       mhz = 64'd8372018;
            1:       mhz = 64'd8869844;
            2:       mhz = 64'd9397273;
            3:       mhz = 64'd9956063;
            4:       mhz = 64'd10548082;
            5:       mhz = 64'd11175303;
            6:       mhz = 64'd11839822;
            7:       mhz = 64'd12543854;
            8:       mhz = 64'd13289750;
            9:       mhz = 64'd14080000;
            10:      mhz = 64'd14917240;
            default: mhz = 64'd15804266;
        endcase
        num = (mhz << 32) >> (4'd10 - octave);
        return 32'((num + STEP_DEN / 64'd2) / STEP_DEN);
    endfunction

    function automatic t_step_tab build_step();
        t_step_tab tab;
        for (int i = 0; i < NOTE_CNT; i++) begin
            tab[i] = step_at(i);
        end
        return tab;
    endfunction

endpackage

@@ hw/rtl/svr_sine_rom.sv @@
// ----------------------------------------------------------------------------
// svr_sine_rom
// Full-cycle sine table with a registered read port.
// ----------------------------------------------------------------------------
module svr_sine_rom (
    input  logic                           i_clk,
    input  logic [svr_pkg::SINE_IDX_W-1:0] i_addr,
    output logic signed [15:0]             o_data
);
    import svr_pkg::*;

    localparam t_sine_tab SINE_TAB = build_sine();

    logic signed [15:0] r_data;

    always_ff @(posedge i_clk) begin
        r_data <= SINE_TAB[i_addr];
    end

    assign o_data = r_data;

endmodule

@@ hw/rtl/sine_voice_with_release.sv @@
// A tick word runs through the exec, two multiply and write-back states before o_out_valid rises.
// A new word is taken only in idle or at write-back; a tick waits in write-back while the output is held.
// The next word is taken at the write-back edge, its state forwarded past the voice RAM.
// Reset (synchronous, active low) empties the voice, clears the output valid and sets volume to 100.
// ----------------------------------------------------------------------------
// sine_voice_with_release
// One sine voice with note level and an exponential release, state held in a
// single-entry voice RAM that is read, updated and written back per word.
// ----------------------------------------------------------------------------
`include "sine_voice_with_release_defines.svh"

module sine_voice_with_release (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [6:0]         i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_op,
    input  logic [6:0]         i_note,
    input  logic [6:0]         i_velocity,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [15:0] o_sample,
    output logic               o_active
);
    import svr_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_MUL1 = 3'd2;
    localparam logic [2:0] S_MUL2 = 3'd3;
    localparam logic [2:0] S_WB   = 3'd4;

    localparam t_step_tab STEP_TAB = build_step();

    logic [2:0]         r_state;
    logic [2:0]         n_state;
    logic [6:0]         r_mvol;
    t_voice             r_mem [1];
    logic               r_mem_vld;
    t_voice             mem_q;
    t_voice             r_st;
    t_voice             n_wb;
    logic [1:0]         r_op;
    logic [31:0]        r_step;
    logic [13:0]        r_prod;
    logic [30:0]        r_num;
    logic [62:0]        r_lvlp;
    logic [30:0]        r_mag1;
    logic [46:0]        r_mag2;
    logic [30:0]        r_decay;
    logic               r_sneg;
    logic               r_out_vld;
    logic signed [15:0] r_sample;
    logic               r_active;
    logic signed [15:0] rom_data;
    logic [15:0]        sine_mag;
    logic [47:0]        rel_sum;
    logic [31:0]        lvl_sum;
    logic [16:0]        mag_full;
    logic [14:0]        mag_clip;
    logic signed [15:0] snd_sample;
    logic [31:0]        dec_sum;
    logic [15:0]        dec_gain;
    logic signed [15:0] n_sample;
    logic               n_active;
    logic               wb_go;
    logic               wb_fire;
    logic               in_fire;

    svr_sine_rom u_sine_rom (
        .i_clk  (i_clk),
        .i_addr (r_st.phase[31 -: SINE_IDX_W]),
        .o_data (rom_data)
    );

    // A tick may only retire once the output register is free or being taken.
    assign wb_go      = (r_op != OP_TICK) || !r_out_vld || !i_out_stall;
    assign wb_fire    = (r_state == S_WB) && wb_go;
    assign o_in_stall = !((r_state == S_IDLE) || wb_fire);
    assign in_fire    = i_in_valid && !o_in_stall;

    assign mem_q = r_mem_vld ? r_mem[0] : '0;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: n_state = S_MUL1;
            S_MUL1: n_state = S_MUL2;
            S_MUL2: n_state = S_WB;
            S_WB: begin
                if (in_fire) begin
                    n_state = S_EXEC;
                end else if (wb_go) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_mvol  <= VOL_RESET;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_mvol <= (i_cfg_data > VOL_MAX) ? VOL_MAX : i_cfg_data;
            end
        end
    end

    // Voice RAM: one entry, valid bit stands in for the zero reset value.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mem_vld <= 1'b0;
        end else if (wb_fire) begin
            r_mem_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wb_fire) begin
            r_mem[0] <= n_wb;
        end
    end

    // Read stage; a word taken during write-back sees the value being written.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_st   <= wb_fire ? n_wb : mem_q;
            r_op   <= i_op;
            r_step <= STEP_TAB[i_note];
            r_prod <= i_velocity * r_mvol;
        end
    end

    assign sine_mag = rom_data[15] ? 16'(-rom_data) : 16'(rom_data);

    always_ff @(posedge i_clk) begin
        if (r_state == S_EXEC) begin
            r_num <= r_prod * LEVEL_SCALE + 31'(LEVEL_ROUND);
        end
        if (r_state == S_MUL1) begin
            r_lvlp  <= r_num * LEVEL_RECIP;
            r_mag1  <= sine_mag[14:0] * r_st.level;
            r_sneg  <= rom_data[15];
            r_decay <= r_st.gain * DECAY_Q15;
        end
        if (r_state == S_MUL2) begin
            r_mag2 <= r_mag1 * r_st.gain;
        end
    end

    // Round half away from zero on the magnitude, then restore the sign.
    assign rel_sum    = 48'(r_mag2) + (48'd1 << 30);
    assign lvl_sum    = 32'(r_mag1) + 32'd32768;
    assign mag_full   = r_st.releasing ? rel_sum[47:31] : {1'b0, lvl_sum[31:16]};
    assign mag_clip   = (mag_full > 17'd32767) ? 15'h7fff : mag_full[14:0];
    assign snd_sample = r_sneg ? -$signed({1'b0, mag_clip}) : $signed({1'b0, mag_clip});
    assign dec_sum    = 32'(r_decay) + 32'd16384;
    assign dec_gain   = dec_sum[30:15];

    always_comb begin
        n_wb     = r_st;
        n_sample = '0;
        case (r_op)
            OP_TICK: begin
                if (r_st.sounding) begin
                    n_sample   = snd_sample;
                    n_wb.phase = r_st.phase + r_st.step;
                    if (r_st.releasing) begin
                        n_wb.gain     = dec_gain;
                        n_wb.sounding = (dec_gain > GAIN_STOP);
                    end
                end
            end
            OP_NOTE_ON: begin
                n_wb.phase     = '0;
                n_wb.step      = r_step;
                n_wb.level     = 16'(r_lvlp >> LEVEL_SHIFT);
                n_wb.gain      = '0;
                n_wb.releasing = 1'b0;
                n_wb.sounding  = 1'b1;
            end
            OP_NOTE_OFF: begin
                if (!r_st.releasing) begin
                    n_wb.releasing = 1'b1;
                    n_wb.gain      = GAIN_ONE;
                end
            end
            OP_KILL: begin
                n_wb.sounding = 1'b0;
            end
            default: begin
                n_wb = r_st;
            end
        endcase
        n_active = n_wb.sounding;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (wb_fire && (r_op == OP_TICK)) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wb_fire && (r_op == OP_TICK)) begin
            r_sample <= n_sample;
            r_active <= n_active;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_sample    = r_sample;
    assign o_active    = r_active;

    `SVR_ASSERT_NEXT(a_accept_to_exec, in_fire, r_state == S_EXEC, "accepted word did not start")
    `SVR_ASSERT_NEXT(a_tick_gives_word, wb_fire && (r_op == OP_TICK), r_out_vld, "tick lost its word")
    `SVR_ASSERT_NEXT(a_wb_marks_valid, wb_fire, r_mem_vld, "voice RAM entry not marked valid")
    `SVR_ASSERT_NOW(a_gain_bound, r_mem_vld, r_mem[0].gain <= GAIN_ONE, "release gain above one")
    `SVR_ASSERT_NOW(a_no_retire_over_word, wb_fire && (r_op == OP_TICK) && r_out_vld, !i_out_stall, "output word overwritten")

endmodule

@@ tb/tb_sine_voice_with_release.sv @@
// ----------------------------------------------------------------------------
// tb_sine_voice_with_release
// Self-checking bench for the sine voice: a short table of directed words,
// then random note phrases under several volume settings. The bench keeps
// its own copy of the voice state and predicts every tick sample bit for bit.
// ----------------------------------------------------------------------------
module tb_sine_voice_with_release;
    timeunit 1ns;
    timeprecision 1ps;

    import svr_pkg::*;

    localparam int          TAB_SIZE   = 1024;
    localparam int          RATE_HZ    = 48000;
    localparam logic [63:0] Q30_UNITY  = 64'd1073741824;
    localparam logic [63:0] Q30_TURN   = 64'd6746518852;
    localparam logic [63:0] Q30_HALF   = 64'd3373259426;
    localparam logic [63:0] Q30_QUART  = 64'd1686629713;
    localparam logic [15:0] TAIL_START = 16'd32768;
    localparam logic [15:0] TAIL_FLOOR = 16'd163;
    localparam logic [63:0] TAIL_DECAY = 64'd32440;
    localparam int          VOL_TOP    = 100;
    localparam int          DRAIN_WAIT = 8;
    localparam int          PHASE_LEN  = 100;
    localparam int          SCORE_LEN  = 24;

    typedef struct packed {
        logic signed [15:0] smp;
        logic               act;
    } t_voice_word;

    typedef struct packed {
        logic [1:0]         op;
        logic [6:0]         note;
        logic [6:0]         vel;
        logic               known;
        logic signed [15:0] smp;
        logic               act;
    } t_score_row;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [6:0]         cfg_data;
    logic               in_valid;
    logic               in_stall;
    logic [1:0]         op;
    logic [6:0]         note;
    logic [6:0]         velocity;
    logic               out_valid;
    logic               out_stall;
    logic signed [15:0] out_sample;
    logic               active;

    // Voice state as the bench sees it.
    logic [6:0]  vol_pct;
    logic [31:0] acc_phase;
    logic [31:0] acc_step;
    logic [15:0] note_lvl;
    logic [15:0] tail_gain;
    logic        tail_on;
    logic        voice_on;

    t_voice_word due_samples[$];
    int          fail_count;
    int          words_sent;
    int          burst_left;

    // Rows with a typed result hold values that follow directly from the
    // voice being idle or from a phase of zero right after a note on.
    t_score_row score [SCORE_LEN] = '{
        '{OP_TICK,     7'd0,   7'd0,   1'b1, 16'sd0, 1'b0},
        '{OP_NOTE_OFF, 7'd0,   7'd0,   1'b0, 16'sd0, 1'b0},
        '{OP_TICK,     7'd0,   7'd0,   1'b1, 16'sd0, 1'b0},
        '{OP_NOTE_ON,  7'd0,   7'd127, 1'b0, 16'sd0, 1'b0},
        '{OP_TICK,     7'd0,   7'd0,   1'b1, 16'sd0, 1'b1},
        '{OP_TICK,     7'd0,   7'd0,   1'b0, 16'sd0, 1'b0},
        '{OP_TICK,     7'd0,   7'd0,   1'b0, 16'sd0, 1'b0},
        '{OP_NOTE_ON,  7'd127, 7'd127, 1'b0, 16'sd0, 1'b0},
        '{OP_TICK,     7'd0,   7'd0,   1'b1, 16'sd0, 1'b1},
        '{OP_TICK,     7'd0,   7'd0,   1'b0, 16'sd0, 1'b0},
        '{OP_TICK,     7'd0,   7'd0,   1'b0, 16'sd0, 1'b0},
        '{OP_NOTE_OFF, 7'd0,   7'd0,   1'b0, 16'sd0, 1'b0},
        '{OP_TICK,     7'd0,   7'd0,   1'b0, 16'sd0, 1'b0},
        '{OP_TICK,     7'd0,   7'd0,   1'b0, 16'sd0, 1'b0},
        '{OP_NOTE_OFF, 7'd0,   7'd0,   1'b0, 16'sd0, 1'b0},
        '{OP_TICK,     7'd0,   7'd0,   1'b0, 16'sd0, 1'b0},
        '{OP_KILL,     7'd0,   7'd0,   1'b0, 16'sd0, 1'b0},
        '{OP_TICK,     7'd0,   7'd0,   1'b1, 16'sd0, 1'b0},
        '{OP_NOTE_ON,  7'd69,  7'd0,   1'b0, 16'sd0, 1'b0},
        '{OP_TICK,     7'd0,   7'd0,   1'b1, 16'sd0, 1'b1},
        '{OP_TICK,     7'd0,   7'd0,   1'b0, 16'sd0, 1'b0},
        '{OP_NOTE_ON,  7'd60,  7'd1,   1'b0, 16'sd0, 1'b0},
        '{OP_TICK,     7'd0,   7'd0,   1'b0, 16'sd0, 1'b0},
        '{OP_TICK,     7'd0,   7'd0,   1'b0, 16'sd0, 1'b0}
    };

    sine_voice_with_release u_top (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_op       (op),
        .i_note     (note),
        .i_velocity (velocity),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_sample   (out_sample),
        .o_active   (active)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial begin
        #4_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // Phase step of a MIDI note: top-octave frequency in milli-Hz, shifted
    // down per octave, as a fraction of a turn per sample.
    function automatic logic [31:0] note_step(input logic [6:0] n);
        logic [63:0] mhz;
        logic [63:0] num;
        logic [63:0] den;
        int          octave;
        octave = n / 12;
        case (n % 12)
            0:       mhz = 64'd8372018;
            1:       mhz = 64'd8869844;
            2:       mhz = 64'd9397273;
            3:       mhz = 64'd9956063;
            4:       mhz = 64'd10548082;
            5:       mhz = 64'd11175303;
            6:       mhz = 64'd11839822;
            7:       mhz = 64'd12543854;
            8:       mhz = 64'd13289750;
            9:       mhz = 64'd14080000;
            10:      mhz = 64'd14917240;
            default: mhz = 64'd15804266;
        endcase
        den = 64'd1000 * 64'(RATE_HZ);
        num = (mhz << 32) >> (10 - octave);
        return 32'((num + den / 64'd2) / den);
    endfunction

    // Sine table entry, folded to the first quadrant and evaluated as a
    // nested series; the divisors run 10*11, 8*9, ... 2*3.
    function automatic logic signed [15:0] sine_q15(input logic [9:0] idx);
        logic [63:0]        th;
        logic [63:0]        x2;
        logic [63:0]        t;
        logic [63:0]        q;
        logic               neg;
        logic signed [15:0] v;
        th  = (64'(idx) * Q30_TURN + 64'(TAB_SIZE / 2)) / 64'(TAB_SIZE);
        neg = 1'b0;
        if (th >= Q30_HALF) begin
            neg = 1'b1;
            th  = th - Q30_HALF;
        end
        if (th > Q30_QUART) begin
            th = (Q30_HALF > th) ? Q30_HALF - th : 64'd0;
        end
        x2 = (th * th) >> 30;
        t  = Q30_UNITY;
        for (int k = 0; k < 5; k++) begin
            t = Q30_UNITY - ((x2 * t) >> 30) / 64'((10 - 2 * k) * (11 - 2 * k));
        end
        q = ((((th * t) >> 30) * 64'd32767) + (64'd1 << 29)) >> 30;
        if (q > 64'd32767) begin
            q = 64'd32767;
        end
        v = 16'(q);
        return neg ? -v : v;
    endfunction

    task automatic advance_voice(input logic [1:0] w_op, input logic [6:0] w_note,
                                 input logic [6:0] w_vel, output bit produced,
                                 output t_voice_word word);
        logic signed [15:0] sv;
        logic [63:0]        mag;
        logic [63:0]        r;
        logic [63:0]        lv;
        produced = 1'b0;
        word     = '0;
        case (w_op)
            OP_NOTE_ON: begin
                lv        = 64'(w_vel) * 64'(vol_pct) * 64'd98304;
                acc_phase = '0;
                acc_step  = note_step(w_note);
                note_lvl  = 16'((lv + 64'd63500) / 64'd127000);
                tail_gain = '0;
                tail_on   = 1'b0;
                voice_on  = 1'b1;
            end
            OP_NOTE_OFF: begin
                if (!tail_on) begin
                    tail_on   = 1'b1;
                    tail_gain = TAIL_START;
                end
            end
            OP_KILL: begin
                voice_on = 1'b0;
            end
            default: begin
                produced = 1'b1;
                if (voice_on) begin
                    sv  = sine_q15(10'((64'(acc_phase) * 64'(TAB_SIZE)) >> 32));
                    mag = 64'(sv < 0 ? -sv : sv) * 64'(note_lvl);
                    if (tail_on) begin
                        r = (mag * 64'(tail_gain) + (64'd1 << 30)) >> 31;
                    end else begin
                        r = (mag + (64'd1 << 15)) >> 16;
                    end
                    if (r > 64'd32767) begin
                        r = 64'd32767;
                    end
                    word.smp  = (sv < 0) ? -16'(r) : 16'(r);
                    acc_phase = acc_phase + acc_step;
                    if (tail_on) begin
                        tail_gain = 16'((64'(tail_gain) * TAIL_DECAY + 64'd16384) >> 15);
                        if (tail_gain <= TAIL_FLOOR) begin
                            voice_on = 1'b0;
                        end
                    end
                end
                word.act = voice_on;
            end
        endcase
    endtask

    task automatic log_miss(input string what, input t_voice_word exp_w,
                            input t_voice_word got_w);
        fail_count++;
        if (fail_count <= 10) begin
            $display("%0t ns: %s: expected sample %0d active %0b, got sample %0d active %0b",
                     $realtime, what, exp_w.smp, exp_w.act, got_w.smp, got_w.act);
        end
    endtask

    // Sender: bursts of random length with random gaps, payload held while stalled.
    task automatic send_word(input logic [1:0] w_op, input logic [6:0] w_note,
                             input logic [6:0] w_vel, input bit use_given,
                             input t_voice_word given);
        t_voice_word predicted;
        bit          produced;
        int          gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                @(negedge clk);
                in_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        in_valid <= 1'b1;
        op       <= w_op;
        note     <= w_note;
        velocity <= w_vel;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        advance_voice(w_op, w_note, w_vel, produced, predicted);
        if (produced) begin
            due_samples.push_back(use_given ? given : predicted);
        end
        words_sent++;
    endtask

    task automatic tick_times(input int n);
        repeat (n) send_word(OP_TICK, 7'($urandom), 7'($urandom), 1'b0, '0);
    endtask

    task automatic drain_voice();
        @(negedge clk);
        in_valid <= 1'b0;
        while (due_samples.size() != 0) @(posedge clk);
        burst_left = 0;
    endtask

    task automatic set_volume(input logic [6:0] v);
        drain_voice();
        // Note words give no result, so let the pipeline empty before the write.
        repeat (DRAIN_WAIT) @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(negedge clk);
        cfg_we   <= 1'b0;
        vol_pct = (v > 7'(VOL_TOP)) ? 7'(VOL_TOP) : v;
    endtask

    // One phrase: a note on with random content, some ticks, then a random
    // ending. A long tail lets a full release run out to silence.
    task automatic play_phrase(input bit long_tail);
        int kind;
        send_word(OP_NOTE_ON, 7'($urandom), 7'($urandom), 1'b0, '0);
        tick_times($urandom_range(1, 40));
        kind = $urandom_range(0, 9);
        if (kind <= 4) begin
            send_word(OP_NOTE_OFF, 7'($urandom), 7'($urandom), 1'b0, '0);
            tick_times($urandom_range(1, 80));
            if ($urandom_range(0, 3) == 0) begin
                send_word(OP_NOTE_OFF, 7'($urandom), 7'($urandom), 1'b0, '0);
                tick_times($urandom_range(1, 10));
            end
        end else if (kind == 5) begin
            send_word(OP_KILL, 7'($urandom), 7'($urandom), 1'b0, '0);
            tick_times($urandom_range(1, 5));
        end else if (kind == 6) begin
            repeat ($urandom_range(3, 10)) begin
                send_word(2'($urandom), 7'($urandom), 7'($urandom), 1'b0, '0);
            end
        end
        if (long_tail) begin
            send_word(OP_NOTE_OFF, 7'($urandom), 7'($urandom), 1'b0, '0);
            tick_times(600);
        end
    endtask

    always @(posedge clk) begin : check_out
        t_voice_word got_w;
        t_voice_word exp_w;
        if (rst_n && out_valid && !out_stall) begin
            got_w.smp = out_sample;
            got_w.act = active;
            if (due_samples.size() == 0) begin
                log_miss("word with nothing expected", '0, got_w);
            end else begin
                exp_w = due_samples.pop_front();
                if (got_w !== exp_w) begin
                    log_miss("sample mismatch", exp_w, got_w);
                end
            end
        end
    end

    // Receiver stall: changes its mode after each span of random length.
    initial begin : stall_pattern
        int         mode;
        int         span;
        logic [7:0] pat;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(20, 200);
            pat  = 8'($urandom);
            for (int c = 0; c < span; c++) begin
                @(negedge clk);
                case (mode)
                    0:       out_stall <= 1'b0;
                    1:       out_stall <= 1'($urandom);
                    2:       out_stall <= pat[c % 8];
                    default: out_stall <= ($urandom_range(0, 4) != 0);
                endcase
            end
        end
    end

    initial begin
        int          vol_plan [7];
        int          phase_start;
        bit          first;
        t_voice_word given;
        rst_n      = 1'b0;
        cfg_we     = 1'b0;
        cfg_data   = '0;
        in_valid   = 1'b0;
        op         = OP_TICK;
        note       = '0;
        velocity   = '0;
        fail_count = 0;
        words_sent = 0;
        burst_left = 0;
        vol_pct    = 7'(VOL_TOP);
        acc_phase  = '0;
        acc_step   = '0;
        note_lvl   = '0;
        tail_gain  = '0;
        tail_on    = 1'b0;
        voice_on   = 1'b0;
        vol_plan   = '{100, 0, 127, 1, 101, 50, 0};
        vol_plan[6] = $urandom_range(0, 127);
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < SCORE_LEN; i++) begin
            given.smp = score[i].smp;
            given.act = score[i].act;
            send_word(score[i].op, score[i].note, score[i].vel, score[i].known, given);
        end

        // The first setting is the reset volume, so no write is needed for it.
        for (int p = 0; p < 7; p++) begin
            if (p > 0) begin
                set_volume(7'(vol_plan[p]));
            end
            phase_start = words_sent;
            first       = 1'b1;
            while (words_sent - phase_start < PHASE_LEN) begin
                play_phrase((first && (p == 1 || p == 4)) || $urandom_range(0, 39) == 0);
                first = 1'b0;
                if ($urandom_range(0, 11) == 0) begin
                    drain_voice();
                end
            end
        end

        drain_voice();
        repeat (20) @(posedge clk);
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
